[rtl/smx_pkg.sv]
// smx_pkg: shared types, codes and widths for the stack machine executor
// used by smx_ctrl, smx_dp and stack_memory_machine_exec; no dependencies
package smx_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned AddrBitsDef   = 10;

  localparam int unsigned FuncW     = 3;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned StatusW   = 4;
  localparam int unsigned WordSelW  = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 2;
  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 72;

  // opcodes
  localparam logic [FuncW-1:0] OP_PUSH     = 3'd0;
  localparam logic [FuncW-1:0] OP_POP      = 3'd1;
  localparam logic [FuncW-1:0] OP_LEARN    = 3'd2;
  localparam logic [FuncW-1:0] OP_REMEMBER = 3'd3;
  localparam logic [FuncW-1:0] OP_LOG      = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] STS_OK          = 4'd0;
  localparam logic [StatusW-1:0] STS_NOT_ENABLED = 4'd1;
  localparam logic [StatusW-1:0] STS_TOO_WIDE    = 4'd2;
  localparam logic [StatusW-1:0] STS_POP_EMPTY   = 4'd3;
  localparam logic [StatusW-1:0] STS_LEARN_GOT0  = 4'd4;
  localparam logic [StatusW-1:0] STS_LEARN_GOT1  = 4'd5;
  localparam logic [StatusW-1:0] STS_REM_EMPTY   = 4'd6;
  localparam logic [StatusW-1:0] STS_OUTPUT_OFF  = 4'd7;
  localparam logic [StatusW-1:0] STS_LOG_EMPTY   = 4'd8;
  localparam logic [StatusW-1:0] STS_ASCII_BIG   = 4'd9;
  localparam logic [StatusW-1:0] STS_OVERFLOW    = 4'd10;
  localparam logic [StatusW-1:0] STS_BAD_ADDRESS = 4'd11;
  localparam logic [StatusW-1:0] STS_HALTED      = 4'd12;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MACHINE_EN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WORD_SEL   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OUTPUT_EN  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ASCII      = 2'd3;

  // word size selections
  localparam logic [WordSelW-1:0] WSEL_8  = 2'd0;
  localparam logic [WordSelW-1:0] WSEL_16 = 2'd1;
  localparam logic [WordSelW-1:0] WSEL_32 = 2'd2;
  localparam logic [WordSelW-1:0] WSEL_64 = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LEARN_RD,
    S_MEM_RD
  } ctrl_state_e;

  typedef struct packed {
    logic accept;     // latch the input word, read top of stack
    logic exec;       // first execute step
    logic learn_fin;  // address read back, write data memory
    logic mem_fin;    // memory word read back, replace top
  } ctrl_cmd_t;

  typedef struct packed {
    logic clearing;
    logic out_free;
    logic more_learn;
    logic more_mem;
  } dp_stat_t;

endpackage

[rtl/smx_ctrl.sv]
// smx_ctrl: sequencing state machine of the stack machine executor
// depends on smx_pkg; drives commands to smx_dp and reads its status
module smx_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  smx_pkg::dp_stat_t  stat_i,
  output smx_pkg::ctrl_cmd_t cmd_o
);
  import smx_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (!stat_i.clearing) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          if (stat_i.more_learn) begin
            state_d = S_LEARN_RD;
          end else if (stat_i.more_mem) begin
            state_d = S_MEM_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LEARN_RD, S_MEM_RD: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready    = 1'b0;
    cmd_o            = '0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      S_EXEC:     cmd_o.exec      = stat_i.out_free;
      S_LEARN_RD: cmd_o.learn_fin = stat_i.out_free;
      S_MEM_RD:   cmd_o.mem_fin   = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/smx_dp.sv]
// smx_dp: datapath of the stack machine executor: config registers, stack ram,
// data memory with clearing pass, checks and output register; uses smx_pkg
module smx_dp #(
  parameter int unsigned STACK_DEPTH = smx_pkg::StackDepthDef,
  parameter int unsigned ADDR_BITS   = smx_pkg::AddrBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smx_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [smx_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [smx_pkg::FuncW-1:0]        in_func_i,
  input  logic [smx_pkg::ValueW-1:0]       in_value_i,
  input  smx_pkg::ctrl_cmd_t               cmd_i,
  output smx_pkg::dp_stat_t                stat_o,
  input  logic                             m_ready_i,
  output logic                             m_valid_o,
  output logic [smx_pkg::StatusW-1:0]      m_status_o,
  output logic                             m_emit_valid_o,
  output logic                             m_emit_ascii_o,
  output logic [smx_pkg::ValueW-1:0]       m_emit_value_o
);
  import smx_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned Words = 1 << ADDR_BITS;
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntTwo  = CntW'(2);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  // configuration
  logic                machine_en_q, output_en_q, ascii_q;
  logic [WordSelW-1:0] word_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machine_en_q <= 1'b0;
      word_sel_q   <= WSEL_64;
      output_en_q  <= 1'b0;
      ascii_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MACHINE_EN: machine_en_q <= cfg_data_i[0];
        CFG_WORD_SEL:   word_sel_q   <= cfg_data_i[WordSelW-1:0];
        CFG_OUTPUT_EN:  output_en_q  <= cfg_data_i[0];
        CFG_ASCII:      ascii_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control state
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 halted_q, halted_d;
  logic [ADDR_BITS:0]   clr_q;
  logic                 clearing;

  // item and read-back registers
  logic [FuncW-1:0]     op_q;
  logic [ValueW-1:0]    imm_q;
  logic [ValueW-1:0]    val_q;
  logic [ValueW-1:0]    stk_rdata_q;
  logic [ValueW-1:0]    mem_rdata_q;

  // memories
  logic [ValueW-1:0]    stk_mem [STACK_DEPTH];
  logic [ValueW-1:0]    data_mem [Words];

  logic                 stk_we, stk_re;
  logic [IdxW-1:0]      stk_waddr, stk_raddr;
  logic [ValueW-1:0]    stk_wdata;
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [ValueW-1:0]    mem_wdata;

  // execute decision
  logic [StatusW-1:0]   ex_status;
  logic [CntW-1:0]      ex_cnt;
  logic                 ex_push, ex_emit, ex_more_learn, ex_more_mem;
  logic                 fits, addr_bad, cnt_empty;
  logic [CntW-1:0]      cnt_m1, cnt_m2;

  // completion
  logic                 cpl;
  logic [StatusW-1:0]   cpl_status;
  logic                 cpl_emit;

  logic                 out_valid_q;
  logic                 out_free;

  assign clearing  = ~clr_q[ADDR_BITS];
  assign out_free  = ~out_valid_q | m_ready_i;
  assign cnt_m1    = cnt_q - CntOne;
  assign cnt_m2    = cnt_q - CntTwo;
  assign cnt_empty = (cnt_q == '0);
  assign addr_bad  = |stk_rdata_q[ValueW-1:ADDR_BITS];

  always_comb begin
    case (word_sel_q)
      WSEL_8:  fits = ~|imm_q[ValueW-1:8];
      WSEL_16: fits = ~|imm_q[ValueW-1:16];
      WSEL_32: fits = ~|imm_q[ValueW-1:32];
      default: fits = 1'b1;
    endcase
  end

  // top of stack sits in stk_rdata_q during the execute step
  always_comb begin
    ex_status     = STS_OK;
    ex_cnt        = cnt_q;
    ex_push       = 1'b0;
    ex_emit       = 1'b0;
    ex_more_learn = 1'b0;
    ex_more_mem   = 1'b0;
    if (halted_q) begin
      ex_status = STS_HALTED;
    end else begin
      case (op_q)
        OP_PUSH: begin
          if (!machine_en_q)       ex_status = STS_NOT_ENABLED;
          else if (!fits)          ex_status = STS_TOO_WIDE;
          else if (cnt_q >= CntFull) ex_status = STS_OVERFLOW;
          else begin
            ex_push = 1'b1;
            ex_cnt  = cnt_q + CntOne;
          end
        end
        OP_POP: begin
          if (!machine_en_q)   ex_status = STS_NOT_ENABLED;
          else if (cnt_empty)  ex_status = STS_POP_EMPTY;
          else                 ex_cnt    = cnt_m1;
        end
        OP_LEARN: begin
          if (!machine_en_q)   ex_status = STS_NOT_ENABLED;
          else if (cnt_empty)  ex_status = STS_LEARN_GOT0;
          else if (cnt_q == CntOne) begin
            ex_status = STS_LEARN_GOT1;
            ex_cnt    = '0;
          end else begin
            ex_more_learn = 1'b1;
          end
        end
        OP_REMEMBER: begin
          if (!machine_en_q)   ex_status = STS_NOT_ENABLED;
          else if (cnt_empty)  ex_status = STS_REM_EMPTY;
          else if (addr_bad) begin
            ex_status = STS_BAD_ADDRESS;
            ex_cnt    = cnt_m1;
          end else begin
            ex_more_mem = 1'b1;
          end
        end
        OP_LOG: begin
          if (!output_en_q)        ex_status = STS_OUTPUT_OFF;
          else if (!machine_en_q)  ex_status = STS_NOT_ENABLED;
          else if (cnt_empty)      ex_status = STS_LOG_EMPTY;
          else begin
            ex_cnt = cnt_m1;
            if (ascii_q && |stk_rdata_q[ValueW-1:8]) ex_status = STS_ASCII_BIG;
            else                                      ex_emit   = 1'b1;
          end
        end
        default: ex_status = STS_HALTED;
      endcase
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    halted_d   = halted_q;
    cpl        = 1'b0;
    cpl_status = STS_OK;
    cpl_emit   = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = cnt_q[IdxW-1:0];
    stk_wdata  = imm_q;
    stk_re     = 1'b0;
    stk_raddr  = cnt_m1[IdxW-1:0];
    mem_we     = clearing;
    mem_waddr  = clr_q[ADDR_BITS-1:0];
    mem_wdata  = '0;
    mem_re     = 1'b0;
    if (cmd_i.accept) begin
      stk_re = 1'b1;
    end else if (cmd_i.exec) begin
      cnt_d = ex_cnt;
      if (ex_more_learn) begin
        stk_re    = 1'b1;
        stk_raddr = cnt_m2[IdxW-1:0];
      end else if (ex_more_mem) begin
        mem_re = 1'b1;
      end else begin
        cpl        = 1'b1;
        cpl_status = ex_status;
        cpl_emit   = ex_emit;
        stk_we     = ex_push;
      end
    end else if (cmd_i.learn_fin) begin
      cnt_d = cnt_m2;
      cpl   = 1'b1;
      if (addr_bad) begin
        cpl_status = STS_BAD_ADDRESS;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = stk_rdata_q[ADDR_BITS-1:0];
        mem_wdata = val_q;
      end
    end else if (cmd_i.mem_fin) begin
      cpl       = 1'b1;
      stk_we    = 1'b1;
      stk_waddr = cnt_m1[IdxW-1:0];
      stk_wdata = mem_rdata_q;
    end
    if (cpl && (cpl_status != STS_OK)) halted_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      halted_q    <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (cpl)            out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_func_i;
      imm_q <= in_value_i;
    end
    if (cmd_i.exec) val_q <= stk_rdata_q;
    if (cpl) begin
      m_status_o     <= cpl_status;
      m_emit_valid_o <= cpl_emit;
      m_emit_ascii_o <= cpl_emit & ascii_q;
      m_emit_value_o <= cpl_emit ? stk_rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) data_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= data_mem[stk_rdata_q[ADDR_BITS-1:0]];
  end

  assign m_valid_o         = out_valid_q;
  assign stat_o.clearing   = clearing;
  assign stat_o.out_free   = out_free;
  assign stat_o.more_learn = ex_more_learn;
  assign stat_o.more_mem   = ex_more_mem;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("stack count above depth");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cpl && cpl_status != STS_OK) |=> halted_q)
    else $error("error result did not halt the machine");

  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_emit_valid_o) |-> (m_status_o == STS_OK))
    else $error("emitted word with error status");

  a_no_item_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(cmd_i.accept || cmd_i.exec || cmd_i.learn_fin || cmd_i.mem_fin))
    else $error("item work during memory clearing pass");

endmodule

[rtl/stack_memory_machine_exec.sv]
// stack_memory_machine_exec: top level of the stack machine executor
// instantiates smx_ctrl and smx_dp; types and codes from smx_pkg
//
// Usage: each input word on s_axis is one decoded instruction (push, pop,
// learn, remember, log). Every instruction gives exactly one result word on
// m_axis with a status code and, for a successful log, the emitted value.
// Any error halts the machine; later instructions return the halted status
// until reset. Configuration is written on cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle.
// Timing: an accepted word reads the top of stack from the single-port stack
// ram, then executes. Push, pop, log and errors caught there give their result
// from that step; learn (two or more entries) adds a second stack read and
// remember (good address) a data memory read; then the next word is accepted.
// Reset: configuration returns to defaults, the stack empties, and a clearing
// pass zeroes all 2^ADDR_BITS data memory words (1024 by default);
// s_axis_tready stays low during that pass.
// Stall: the result sits in an output register; the next instruction is
// accepted meanwhile and waits in its execute step until the result is taken.
module stack_memory_machine_exec #(
  parameter int unsigned STACK_DEPTH = smx_pkg::StackDepthDef,
  parameter int unsigned ADDR_BITS   = smx_pkg::AddrBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smx_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smx_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] func, [66:3] push_value, [71:67] zero
  input  logic [smx_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] status, [4] emit_valid, [68:5] emit_value, [71:69] zero
  output logic [smx_pkg::OutTdataW-1:0]  m_axis_tdata,
  // [0] emit_ascii
  output logic                           m_axis_tuser
);
  import smx_pkg::*;

  ctrl_cmd_t           cmd;
  dp_stat_t            stat;
  logic [StatusW-1:0]  status;
  logic                emit_valid;
  logic [ValueW-1:0]   emit_value;

  smx_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  smx_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_func_i      (s_axis_tdata[FuncW-1:0]),
    .in_value_i     (s_axis_tdata[FuncW+ValueW-1:FuncW]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .m_status_o     (status),
    .m_emit_valid_o (emit_valid),
    .m_emit_ascii_o (m_axis_tuser),
    .m_emit_value_o (emit_value)
  );

  assign m_axis_tdata = {(OutTdataW - StatusW - 1 - ValueW)'(0), emit_value, emit_valid, status};

endmodule

[tb/stack_memory_machine_exec_test.sv]
`timescale 1ns / 1ps
// stack_memory_machine_exec_test: self-checking bench for the stack machine executor
// predicts every status and emitted value in step with the stream; needs smx_pkg
module stack_memory_machine_exec_test;
  import smx_pkg::*;

  localparam int unsigned STACK_DEPTH = StackDepthDef;
  localparam int unsigned ADDR_BITS   = AddrBitsDef;
  localparam int unsigned MEM_WORDS   = 1 << ADDR_BITS;
  localparam int unsigned WATCHDOG    = 5000;
  localparam int unsigned LONG_HOLD   = 80;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               emit_valid;
    logic               emit_ascii;
    logic [ValueW-1:0]  emit_value;
  } exec_result_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [ValueW-1:0] imm;
    exec_result_t      want;
  } instr_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  stack_memory_machine_exec dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [2:0] func, [66:3] push_value, [71:67] zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [3:0] status, [4] emit_valid, [68:5] emit_value
    .m_axis_tuser  (m_axis_tuser)    // [0] emit_ascii
  );

  always #1 clk_i = ~clk_i;

  // machine image kept by the bench
  logic [ValueW-1:0]   stack_m [STACK_DEPTH];
  logic [ValueW-1:0]   mem_m [MEM_WORDS];
  int unsigned         depth_m;
  logic                halted_m;
  logic                cfg_machine;
  logic [WordSelW-1:0] cfg_wsel;
  logic                cfg_out;
  logic                cfg_ascii;

  instr_t       instr_q[$];
  exec_result_t pending_results[$];
  instr_t       offered;
  int unsigned  offered_cnt = 0;
  int unsigned  taken_cnt = 0;
  logic         in_taken = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_asks = 0;
  int unsigned  hold_done = 0;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  err_cnt = 0;

  function automatic logic [ValueW-1:0] word_max();
    case (cfg_wsel)
      WSEL_8:  return 64'hff;
      WSEL_16: return 64'hffff;
      WSEL_32: return 64'hffff_ffff;
      default: return '1;
    endcase
  endfunction

  function automatic logic fits_word(input logic [ValueW-1:0] v);
    return (v & ~word_max()) == '0;
  endfunction

  function automatic logic addr_ok(input logic [ValueW-1:0] a);
    return (a >> ADDR_BITS) == '0;
  endfunction

  // one instruction against the machine image, returns the result word it gives
  function automatic exec_result_t execute_instr(input logic [FuncW-1:0] func,
                                                 input logic [ValueW-1:0] imm);
    exec_result_t r;
    logic [StatusW-1:0] st;
    logic [ValueW-1:0] v, a;
    r = '0;
    st = STS_OK;
    v = '0;
    if (halted_m) begin
      st = STS_HALTED;
    end else begin
      case (func)
        OP_PUSH: begin
          if (!cfg_machine) st = STS_NOT_ENABLED;
          else if (!fits_word(imm)) st = STS_TOO_WIDE;
          else if (depth_m >= STACK_DEPTH) st = STS_OVERFLOW;
          else begin
            stack_m[depth_m] = imm;
            depth_m++;
          end
        end
        OP_POP: begin
          if (!cfg_machine) st = STS_NOT_ENABLED;
          else if (depth_m == 0) st = STS_POP_EMPTY;
          else depth_m--;
        end
        OP_LEARN: begin
          if (!cfg_machine) st = STS_NOT_ENABLED;
          else if (depth_m == 0) st = STS_LEARN_GOT0;
          else if (depth_m == 1) begin
            depth_m = 0;
            st = STS_LEARN_GOT1;
          end else begin
            v = stack_m[depth_m-1];
            a = stack_m[depth_m-2];
            depth_m -= 2;
            if (!addr_ok(a)) st = STS_BAD_ADDRESS;
            else mem_m[a[ADDR_BITS-1:0]] = v;
          end
        end
        OP_REMEMBER: begin
          if (!cfg_machine) st = STS_NOT_ENABLED;
          else if (depth_m == 0) st = STS_REM_EMPTY;
          else begin
            a = stack_m[depth_m-1];
            if (!addr_ok(a)) begin
              depth_m--;
              st = STS_BAD_ADDRESS;
            end else begin
              stack_m[depth_m-1] = mem_m[a[ADDR_BITS-1:0]];
            end
          end
        end
        OP_LOG: begin
          // output enable is checked ahead of the machine enable
          if (!cfg_out) st = STS_OUTPUT_OFF;
          else if (!cfg_machine) st = STS_NOT_ENABLED;
          else if (depth_m == 0) st = STS_LOG_EMPTY;
          else begin
            v = stack_m[depth_m-1];
            depth_m--;
            if (cfg_ascii && v > 64'd255) st = STS_ASCII_BIG;
          end
        end
        default: st = STS_HALTED;
      endcase
      if (st != STS_OK) halted_m = 1'b1;
    end
    r.status = st;
    if (st == STS_OK && func == OP_LOG) begin
      r.emit_valid = 1'b1;
      r.emit_ascii = cfg_ascii;
      r.emit_value = v;
    end
    return r;
  endfunction

  // true when the op would run without an error on the current image, given an enabled machine and a fitting push value
  function automatic logic op_is_legal(input logic [FuncW-1:0] op);
    case (op)
      OP_PUSH: return depth_m < STACK_DEPTH;
      OP_POP:  return depth_m > 0;
      OP_LEARN: begin
        if (depth_m < 2) return 1'b0;
        return addr_ok(stack_m[depth_m-2]);
      end
      OP_REMEMBER: begin
        if (depth_m < 1) return 1'b0;
        return addr_ok(stack_m[depth_m-1]);
      end
      OP_LOG: begin
        if (!cfg_out || depth_m < 1) return 1'b0;
        return !cfg_ascii || stack_m[depth_m-1] <= 64'd255;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [ValueW-1:0] any_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ValueW-1:0] rand_addr();
    logic [ValueW-1:0] lim;
    lim = word_max();
    if (lim > MEM_WORDS - 1) lim = MEM_WORDS - 1;
    if ($urandom_range(7) == 0) return lim;
    return 64'($urandom_range(lim[31:0]));
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 40) return rand_addr();
    if (k < 55) return 64'($urandom_range(255));
    if (k < 65) return ($urandom_range(1) == 0) ? word_max() : '0;
    return any_word() & word_max();
  endfunction

  task automatic issue(input logic [FuncW-1:0] func, input logic [ValueW-1:0] imm);
    instr_t it;
    it.func = func;
    it.imm  = imm;
    it.want = execute_instr(func, imm);
    instr_q = {instr_q, it};
  endtask

  // error-free program with random content, mostly store/load sequences
  task automatic add_random(input int unsigned n);
    int unsigned made;
    int unsigned k;
    logic [FuncW-1:0] op;
    made = 0;
    while (made < n) begin
      k = $urandom_range(99);
      if (k < 20 && depth_m + 2 <= STACK_DEPTH) begin
        issue(OP_PUSH, rand_addr());
        issue(OP_PUSH, rand_value());
        issue(OP_LEARN, any_word());
        made += 3;
      end else if (k < 35 && depth_m < STACK_DEPTH) begin
        issue(OP_PUSH, rand_addr());
        issue(OP_REMEMBER, any_word());
        made += 2;
      end else begin
        // lean toward consuming ops when the stack runs deep
        if (depth_m > STACK_DEPTH - 8) op = FuncW'($urandom_range(OP_LOG, OP_POP));
        else op = FuncW'($urandom_range(OP_LOG, OP_PUSH));
        if (op_is_legal(op)) begin
          issue(op, (op == OP_PUSH) ? rand_value() : any_word());
          made++;
        end
      end
    end
  endtask

  task automatic drain_results();
    while (instr_q.size() != 0 || offered_cnt != taken_cnt || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MACHINE_EN: cfg_machine = val[0];
      CFG_WORD_SEL:   cfg_wsel    = val;
      CFG_OUTPUT_EN:  cfg_out     = val[0];
      CFG_ASCII:      cfg_ascii   = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic start_phase(input logic [WordSelW-1:0] wsel, input logic [CfgDataW-1:0] out_en,
                             input logic [CfgDataW-1:0] ascii, input int unsigned send_pct,
                             input int unsigned recv_pct);
    drain_results();
    write_reg(CFG_WORD_SEL, wsel);
    write_reg(CFG_OUTPUT_EN, out_en);
    write_reg(CFG_ASCII, ascii);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic check_field(input string what, input logic [ValueW-1:0] want,
                             input logic [ValueW-1:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h got %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // sender: a word stays up until taken, new words go out at random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = instr_q.pop_front();
        offered_cnt++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, offered.imm, offered.func};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done++;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: commits expectations on input words, checks result words
  always @(posedge clk_i) begin
    exec_result_t got, want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results = {pending_results, offered.want};
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tdata[3:0];
        got.emit_valid = m_axis_tdata[4];
        got.emit_value = m_axis_tdata[68:5];
        got.emit_ascii = m_axis_tuser;
        if (pending_results.size() == 0) begin
          $display("%0t result word with none pending: expected none got %h", $time, got);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("emit_valid", 64'(want.emit_valid), 64'(got.emit_valid));
          check_field("emit_ascii", 64'(want.emit_ascii), 64'(got.emit_ascii));
          check_field("emit_value", want.emit_value, got.emit_value);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
          $display("%0t watchdog: no progress for %0d cycles", $time, quiet_cycles);
          $display("stack_memory_machine_exec: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [StatusW-1:0] target;
    for (int i = 0; i < MEM_WORDS; i++) mem_m[i] = '0;
    depth_m     = 0;
    halted_m    = 1'b0;
    cfg_machine = 1'b0;
    cfg_wsel    = WSEL_64;
    cfg_out     = 1'b0;
    cfg_ascii   = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(CFG_MACHINE_EN, 2'd0);
    write_reg(CFG_MACHINE_EN, 2'd1);
    write_reg(CFG_WORD_SEL, WSEL_64);
    write_reg(CFG_OUTPUT_EN, 2'd1);
    write_reg(CFG_ASCII, 2'd0);
    send_idle_pct = 15;
    recv_idle_pct = 57;

    // extremes of the value, store and load at the top address, unwritten memory
    issue(OP_PUSH, '0);
    issue(OP_PUSH, '1);
    issue(OP_LOG, any_word());
    issue(OP_LOG, any_word());
    issue(OP_PUSH, 64'(MEM_WORDS - 1));
    issue(OP_PUSH, 64'ha5a5_5a5a_0f0f_f0f0);
    issue(OP_LEARN, any_word());
    issue(OP_PUSH, 64'(MEM_WORDS - 1));
    issue(OP_REMEMBER, any_word());
    issue(OP_LOG, any_word());
    issue(OP_PUSH, '0);
    issue(OP_REMEMBER, any_word());
    issue(OP_POP, any_word());
    issue(OP_PUSH, 64'h8000_0000_0000_0001);
    issue(OP_POP, any_word());

    // byte words with character output; ascii written as 3 to see the mask
    start_phase(WSEL_8, 2'd1, 2'd3, 15, 57);
    issue(OP_PUSH, 64'd255);
    issue(OP_LOG, any_word());
    issue(OP_PUSH, '0);
    issue(OP_PUSH, 64'h41);
    issue(OP_LEARN, any_word());
    issue(OP_PUSH, '0);
    issue(OP_REMEMBER, any_word());
    issue(OP_LOG, any_word());

    start_phase(WSEL_64, 2'd1, 2'd0, 15, 57);
    add_random(110);
    start_phase(WSEL_8, 2'd1, 2'd1, 15, 57);
    add_random(120);
    start_phase(WSEL_16, 2'd1, 2'd0, 57, 15);
    add_random(120);
    start_phase(WSEL_32, 2'd1, 2'd1, 57, 15);
    add_random(120);
    start_phase(WSEL_64, 2'd0, 2'd0, 0, 0);
    add_random(120);

    // fill the stack to the top while the receiver holds off
    start_phase(WSEL_64, 2'd1, 2'd0, 0, 0);
    hold_asks++;
    while (depth_m < STACK_DEPTH) issue(OP_PUSH, rand_addr());
    add_random(40);

    // one error ends the program; every later word must see the halted status
    start_phase(WSEL_64, 2'd1, 2'd0, 0, 0);
    while (depth_m > 0) issue(OP_POP, any_word());
    drain_results();
    target = StatusW'(STS_NOT_ENABLED + $urandom_range(11));
    case (target)
      STS_NOT_ENABLED: begin
        write_reg(CFG_MACHINE_EN, 2'd0);
        issue(OP_PUSH, any_word());
      end
      STS_TOO_WIDE: begin
        write_reg(CFG_WORD_SEL, WSEL_8);
        issue(OP_PUSH, any_word() | 64'h100);
      end
      STS_POP_EMPTY:  issue(OP_POP, any_word());
      STS_LEARN_GOT0: issue(OP_LEARN, any_word());
      STS_LEARN_GOT1: begin
        issue(OP_PUSH, rand_addr());
        issue(OP_LEARN, any_word());
      end
      STS_REM_EMPTY: issue(OP_REMEMBER, any_word());
      STS_OUTPUT_OFF: begin
        write_reg(CFG_OUTPUT_EN, 2'd0);
        write_reg(CFG_MACHINE_EN, 2'd0);
        issue(OP_LOG, any_word());
      end
      STS_LOG_EMPTY: issue(OP_LOG, any_word());
      STS_ASCII_BIG: begin
        write_reg(CFG_ASCII, 2'd1);
        issue(OP_PUSH, any_word() | 64'h100);
        issue(OP_LOG, any_word());
      end
      STS_OVERFLOW: repeat (STACK_DEPTH + 1) issue(OP_PUSH, any_word());
      STS_BAD_ADDRESS: begin
        issue(OP_PUSH, any_word() | 64'(MEM_WORDS));
        if ($urandom_range(1) == 0) begin
          issue(OP_PUSH, any_word());
          issue(OP_LEARN, any_word());
        end else begin
          issue(OP_REMEMBER, any_word());
        end
      end
      default: issue(FuncW'(OP_LOG + 1 + $urandom_range(2)), any_word());  // invalid opcode
    endcase
    for (int f = 0; f < (1 << FuncW); f++) issue(FuncW'(f), any_word());
    repeat (16) issue(FuncW'($urandom), any_word());

    drain_results();
    repeat (10) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("stack_memory_machine_exec: match");
    end else begin
      $display("stack_memory_machine_exec: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/smx_pkg.sv
rtl/smx_ctrl.sv
rtl/smx_dp.sv
rtl/stack_memory_machine_exec.sv
tb/stack_memory_machine_exec_test.sv
